// File: design/ptw_pkg.sv
package ptw_pkg;

  // Table geometry
  localparam int unsigned Levels    = 4;
  localparam int unsigned IndexBits = 9;
  localparam int unsigned VaBits    = 48;
  localparam int unsigned PageShift = 12;

  // Field widths
  localparam int unsigned AddrW   = 48;
  localparam int unsigned SpanW   = 40;
  localparam int unsigned DescW   = 64;
  localparam int unsigned LvlW    = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned BaseW = AddrW - PageShift;
  localparam int unsigned CmpW  = (VaBits + 1 > AddrW) ? VaBits + 1 : AddrW;

  typedef logic [AddrW-1:0]     addr_t;
  typedef logic [VaBits-1:0]    va_t;
  typedef logic [IndexBits-1:0] idx_t;
  typedef logic [BaseW-1:0]     base_t;
  typedef logic [LvlW-1:0]      lvl_t;
  typedef logic [SpanW-1:0]     span_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_MAP  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROOT  = 2'd0,
    CFG_START = 2'd1,
    CFG_END   = 2'd2
  } cfg_idx_e;

  // One result item
  typedef struct packed {
    kind_e kind;
    lvl_t  level;
    addr_t oa;
    addr_t da;
    addr_t va;
    span_t span;
    logic  last;
  } result_t;

  // Bit position of the lowest VA bit translated at a level
  function automatic int unsigned level_shift(lvl_t l);
    return PageShift + (Levels - 1 - int'(l)) * IndexBits;
  endfunction

  function automatic span_t level_span(lvl_t l);
    int unsigned s;
    s = level_shift(l);
    return (s >= SpanW) ? '0 : (span_t'(1) << s);
  endfunction

  // Clears the bits below a level's span
  function automatic va_t align_mask(lvl_t l);
    return va_t'('1) << level_shift(l);
  endfunction

  function automatic idx_t index_of(va_t va, lvl_t l);
    return idx_t'(va >> level_shift(l));
  endfunction

endpackage

// File: design/ptw_addcmp.sv
// Shared adder and end-of-range comparator
module ptw_addcmp (
  input  ptw_pkg::va_t   a_i,
  input  ptw_pkg::va_t   b_i,
  input  ptw_pkg::addr_t end_i,
  output ptw_pkg::va_t   sum_o,
  output logic           stop_o
);
  import ptw_pkg::*;

  logic [VaBits:0] sum_full;

  assign sum_full = {1'b0, a_i} + {1'b0, b_i};
  assign sum_o    = sum_full[VaBits-1:0];

  // carry out means the cursor left the address space
  assign stop_o = sum_full[VaBits] | (CmpW'(sum_full) >= CmpW'(end_i));

endmodule

// File: design/ptw_outreg.sv
// Output register: holds one result until the sink takes it
module ptw_outreg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ptw_pkg::result_t res_i,
  input  logic             out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output ptw_pkg::result_t res_o
);
  import ptw_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: design/page_table_range_walker.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------------
// in       | in_valid_i/in_stall_o  | action_i, descriptor_word_i
// out      | out_valid_o/out_stall_i| kind_o, walk_level_o, phys_addr_o,
//          |                        | descriptor_address_o, map_vaddr_o,
//          |                        | span_bytes_o, last_o
// cfg      | cfg_we_i               | cfg_addr_i, cfg_wdata_i
//
// A start goes through the start and request states to its read request, a table
// descriptor through classify and request, an invalid entry through classify, advance
// and request. A mapping gives its result in the map state, then advances to the next
// request; past the last index the climb goes up one level per cycle (up to 3 levels).
// Reset clears the sequencer, the scan flag and the registers; tables need no clear.
// A stalled output holds the sequencer in its emit state; in_stall_o is high until idle.
module page_table_range_walker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [ptw_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  ptw_pkg::addr_t           cfg_wdata_i,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [ptw_pkg::DescW-1:0] descriptor_word_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output ptw_pkg::lvl_t            walk_level_o,
  output ptw_pkg::addr_t           phys_addr_o,
  output ptw_pkg::addr_t           descriptor_address_o,
  output ptw_pkg::addr_t           map_vaddr_o,
  output ptw_pkg::span_t           span_bytes_o,
  output logic                     last_o
);
  import ptw_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_START = 9'b000000010,
    ST_CLASS = 9'b000000100,
    ST_MAP   = 9'b000001000,
    ST_ADV   = 9'b000010000,
    ST_CLIMB = 9'b000100000,
    ST_REQ   = 9'b001000000,
    ST_DONE  = 9'b010000000,
    ST_ERR   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   scan_q, scan_d;
  addr_t  root_q, start_q, end_q;
  lvl_t   lv_q, lv_d;
  idx_t   idx_q [Levels];
  idx_t   idx_d [Levels];
  base_t  base_q [Levels];
  base_t  base_d [Levels];
  va_t    cur_q, cur_d;
  addr_t  desc_q;

  logic    in_xfer;
  logic    out_free;
  logic    emit;
  result_t emit_res;
  result_t out_res;
  va_t     alu_a, alu_b, alu_sum;
  logic    alu_stop;
  addr_t   rd_addr;
  va_t     lv_mask;
  lvl_t    lv_next;
  logic    idx_full;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      start_q <= '0;
      end_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ROOT:  root_q  <= cfg_wdata_i;
        CFG_START: start_q <= cfg_wdata_i;
        CFG_END:   end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-level helpers, all at the current level
  assign rd_addr  = {base_q[lv_q], PageShift'(0)} + (AddrW'(idx_q[lv_q]) << 3);
  assign lv_mask  = align_mask(lv_q);
  assign lv_next  = lv_q + lvl_t'(1);
  assign idx_full = &idx_q[lv_q];

  // shared unit: range check at start, step to next entry when advancing
  assign alu_a = (state_q == ST_ADV) ? (cur_q & lv_mask) : cur_q;
  assign alu_b = (state_q == ST_ADV) ? va_t'(level_span(lv_q)) : '0;

  ptw_addcmp u_addcmp (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .end_i  (end_q),
    .sum_o  (alu_sum),
    .stop_o (alu_stop)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    scan_d   = scan_q;
    lv_d     = lv_q;
    cur_d    = cur_q;
    idx_d    = idx_q;
    base_d   = base_q;
    emit     = 1'b0;
    emit_res = '{kind: KIND_DONE, level: '0, oa: '0, da: '0, va: '0, span: '0,
                 last: 1'b1};

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!action_i) begin
            scan_d = 1'b1;
            lv_d   = '0;
            for (int i = 0; i < Levels; i++) begin
              idx_d[i]  = '0;
              base_d[i] = '0;
            end
            cur_d     = start_q[VaBits-1:0];
            base_d[0] = root_q[AddrW-1:PageShift];
            idx_d[0]  = index_of(start_q[VaBits-1:0], '0);
            state_d   = ST_START;
          end else if (scan_q) begin
            state_d = ST_CLASS;
          end
        end
      end

      ST_START: begin
        state_d = alu_stop ? ST_DONE : ST_REQ;
      end

      // classify the returned descriptor
      ST_CLASS: begin
        if (!desc_q[0]) begin
          state_d = ST_ADV;
        end else if (desc_q[1] && (int'(lv_q) + 1 < Levels)) begin
          lv_d           = lv_next;
          base_d[lv_next] = desc_q[AddrW-1:PageShift];
          idx_d[lv_next]  = index_of(cur_q, lv_next);
          state_d        = ST_REQ;
        end else if (!desc_q[1] && (lv_q == '0 || int'(lv_q) == Levels - 1)) begin
          state_d = ST_ERR;
        end else begin
          state_d = ST_MAP;
        end
      end

      ST_MAP: begin
        emit_res.kind  = KIND_MAP;
        emit_res.level = lv_q;
        emit_res.oa    = AddrW'(desc_q[VaBits-1:0] & lv_mask);
        emit_res.da    = rd_addr;
        emit_res.va    = AddrW'(cur_q & lv_mask);
        emit_res.span  = level_span(lv_q);
        emit_res.last  = 1'b0;
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_ADV;
        end
      end

      // step right by one entry
      ST_ADV: begin
        if (alu_stop) begin
          state_d = ST_DONE;
        end else begin
          cur_d = alu_sum;
          if (!idx_full) begin
            idx_d[lv_q] = idx_q[lv_q] + idx_t'(1);
            state_d     = ST_REQ;
          end else if (lv_q == '0) begin
            state_d = ST_DONE;
          end else begin
            lv_d    = lv_q - lvl_t'(1);
            state_d = ST_CLIMB;
          end
        end
      end

      // one level up per cycle until a table has entries left or level 0 is full
      ST_CLIMB: begin
        if (!idx_full) begin
          idx_d[lv_q] = idx_q[lv_q] + idx_t'(1);
          state_d     = ST_REQ;
        end else if (lv_q == '0) begin
          state_d = ST_DONE;
        end else begin
          lv_d = lv_q - lvl_t'(1);
        end
      end

      ST_REQ: begin
        emit_res.kind  = KIND_REQ;
        emit_res.level = lv_q;
        emit_res.da    = rd_addr;
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          emit    = 1'b1;
          scan_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      ST_ERR: begin
        emit_res.kind  = KIND_ERR;
        emit_res.level = lv_q;
        emit_res.da    = rd_addr;
        if (out_free) begin
          emit    = 1'b1;
          scan_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= 1'b0;
      lv_q    <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      lv_q    <= lv_d;
    end
  end

  // walk context, valid only while a scan runs
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    base_q <= base_d;
    if (in_xfer) begin
      desc_q <= descriptor_word_i[AddrW-1:0];
    end
  end

  ptw_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .res_i       (emit_res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o               = out_res.kind;
  assign walk_level_o         = out_res.level;
  assign phys_addr_o          = out_res.oa;
  assign descriptor_address_o = out_res.da;
  assign map_vaddr_o          = out_res.va;
  assign span_bytes_o         = out_res.span;
  assign last_o               = out_res.last;

endmodule

// File: test/page_table_range_walker_tb.sv
`timescale 1ns / 100ps

module page_table_range_walker_tb;
  import ptw_pkg::*;

  // Input action codes
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_DESC  = 1'b1
  } act_e;

  // Descriptor type bits [1:0]; page shares the table encoding at the last level
  localparam logic [1:0] DESC_INVALID = 2'b00;
  localparam logic [1:0] DESC_BLOCK   = 2'b01;
  localparam logic [1:0] DESC_TABLE   = 2'b11;
  localparam logic [1:0] DESC_PAGE    = 2'b11;

  localparam lvl_t        LAST_LEVEL    = lvl_t'(Levels - 1);
  localparam addr_t       VA_TOP        = '1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS  = 1300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_addr_i;
  addr_t                 cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [DescW-1:0]      descriptor_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            kind_o;
  lvl_t                  walk_level_o;
  addr_t                 phys_addr_o;
  addr_t                 descriptor_address_o;
  addr_t                 map_vaddr_o;
  span_t                 span_bytes_o;
  logic                  last_o;

  // Walker model: registers and scan state
  addr_t reg_root, reg_first, reg_stop;
  lvl_t  cur_lvl;
  idx_t  tbl_idx [Levels];
  base_t tbl_base [Levels];
  addr_t cursor;
  bit    scan_on;

  result_t expected_results[$];

  bit          idle_on;
  int unsigned rx_hold_cycles;
  int unsigned n_in, n_results, n_maps, n_bad, n_done, n_errors;

  page_table_range_walker DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .action_i            (action_i),
    .descriptor_word_i   (descriptor_word_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .walk_level_o        (walk_level_o),
    .phys_addr_o         (phys_addr_o),
    .descriptor_address_o(descriptor_address_o),
    .map_vaddr_o         (map_vaddr_o),
    .span_bytes_o        (span_bytes_o),
    .last_o              (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Walk prediction
  // ---------------------------------------------------------------------------

  // Lowest VA bit translated at a level
  function automatic int unsigned span_shift(input int unsigned l);
    return PageShift + (Levels - 1 - l) * IndexBits;
  endfunction

  function automatic idx_t va_index(input addr_t va, input int unsigned l);
    addr_t t;
    t = va >> span_shift(l);
    return t[IndexBits-1:0];
  endfunction

  function automatic addr_t entry_address();
    return {tbl_base[cur_lvl], 12'h000} + {36'd0, tbl_idx[cur_lvl], 3'b000};
  endfunction

  function automatic void push_result(input kind_e k, input lvl_t l, input addr_t oa,
                                      input addr_t da, input addr_t va, input span_t span,
                                      input logic last);
    result_t r;
    r.kind  = k;
    r.level = l;
    r.oa    = oa;
    r.da    = da;
    r.va    = va;
    r.span  = span;
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  function automatic void push_request_or_done(input bit go_on);
    if (go_on) begin
      push_result(KIND_REQ, cur_lvl, '0, entry_address(), '0, '0, 1'b1);
    end else begin
      scan_on = 1'b0;
      push_result(KIND_DONE, '0, '0, '0, '0, '0, 1'b1);
    end
  endfunction

  // Step one entry right; climb after the last index. 0 when the scan is over.
  function automatic bit advance_cursor();
    int unsigned l;
    logic [AddrW:0] next;
    addr_t keep;
    l = cur_lvl;
    keep = VA_TOP << span_shift(l);
    next = {1'b0, cursor & keep} + ({{AddrW{1'b0}}, 1'b1} << span_shift(l));
    if (next >= {1'b0, reg_stop} || next[AddrW]) return 1'b0;
    cursor = next[AddrW-1:0];
    if (tbl_idx[l] != '1) begin
      tbl_idx[l] = tbl_idx[l] + 1'b1;
      return 1'b1;
    end
    while (l != 0) begin
      l = l - 1;
      if (tbl_idx[l] != '1) begin
        tbl_idx[l] = tbl_idx[l] + 1'b1;
        cur_lvl = lvl_t'(l);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_walk_step(input act_e act, input logic [63:0] word);
    int unsigned l;
    int unsigned sh;
    addr_t da;
    addr_t keep;
    if (act == ACT_START) begin
      scan_on = 1'b1;
      cur_lvl = '0;
      for (int i = 0; i < Levels; i++) begin
        tbl_idx[i]  = '0;
        tbl_base[i] = '0;
      end
      cursor      = reg_first;
      tbl_base[0] = reg_root[AddrW-1:PageShift];
      tbl_idx[0]  = va_index(cursor, 0);
      push_request_or_done(reg_first < reg_stop);
      return;
    end
    // responses with no scan running are dropped
    if (!scan_on) return;
    l  = cur_lvl;
    da = entry_address();
    if (!word[0]) begin
      push_request_or_done(advance_cursor());
    end else if (word[1] && l < LAST_LEVEL) begin
      cur_lvl         = lvl_t'(l + 1);
      tbl_base[l + 1] = word[AddrW-1:PageShift];
      tbl_idx[l + 1]  = va_index(cursor, l + 1);
      push_request_or_done(1'b1);
    end else if (!word[1] && (l == 0 || l == LAST_LEVEL)) begin
      // block where the format allows none
      scan_on = 1'b0;
      push_result(KIND_ERR, lvl_t'(l), '0, da, '0, '0, 1'b1);
    end else begin
      sh   = span_shift(l);
      keep = VA_TOP << sh;
      push_result(KIND_MAP, lvl_t'(l), word[AddrW-1:0] & keep, da, cursor & keep,
                  span_t'(1) << sh, 1'b0);
      push_request_or_done(advance_cursor());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void match_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d level %0d da %0h", $time, kind_o,
                 walk_level_o, descriptor_address_o);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        match_field("kind", want.kind, kind_o);
        match_field("walk_level", want.level, walk_level_o);
        match_field("phys_addr", want.oa, phys_addr_o);
        match_field("descriptor_address", want.da, descriptor_address_o);
        match_field("map_vaddr", want.va, map_vaddr_o);
        match_field("span_bytes", want.span, span_bytes_o);
        match_field("last", want.last, last_o);
        if (want.kind == KIND_MAP) n_maps++;
        if (want.kind == KIND_ERR) n_bad++;
        if (want.kind == KIND_DONE) n_done++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic addr_t rand48();
    logic [63:0] t;
    t = rand_word();
    return t[AddrW-1:0];
  endfunction

  // Random descriptor content with the given type bits
  function automatic logic [63:0] make_desc(input logic [1:0] code);
    logic [63:0] t;
    t = rand_word();
    t[1:0] = code;
    if (code == DESC_INVALID) t[1] = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Receiver throttle; a long hold is counted down here
  initial begin : rx_throttle
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        hold_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // One input transfer; valid stays up when no gap follows
  task automatic send_item(input act_e act, input logic [63:0] word);
    int unsigned gap;
    in_valid_i        <= 1'b1;
    action_i          <= act;
    descriptor_word_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    n_in++;
    predict_walk_step(act, word);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input cfg_idx_e idx, input addr_t value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Registers change only with the walker idle
  task automatic program_regs(input addr_t root, input addr_t first_va, input addr_t stop_va);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    reg_write(CFG_ROOT, root);
    reg_write(CFG_START, first_va);
    reg_write(CFG_END, stop_va);
    cfg_we_i  <= 1'b0;
    reg_root  = root;
    reg_first = first_va;
    reg_stop  = stop_va;
  endtask

  task automatic randomize_range();
    addr_t root, first_va, stop_va, len;
    logic [AddrW:0] sum;
    int unsigned r;
    root     = rand48();
    first_va = rand48();
    r = $urandom_range(0, 99);
    // bias the start toward table ends so the walk climbs
    if (r < 25) begin
      first_va[20:12] = 9'($urandom_range(500, 511));
    end else if (r < 40) begin
      first_va[20:12] = 9'($urandom_range(505, 511));
      first_va[29:21] = 9'($urandom_range(505, 511));
    end else if (r < 48) begin
      first_va[38:21] = '1;
      first_va[20:12] = 9'($urandom_range(508, 511));
    end else if (r < 58) begin
      first_va = VA_TOP - 48'($urandom_range(0, 65535));
    end else if (r < 66) begin
      first_va = '0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      stop_va = first_va;
    end else if (r < 10) begin
      stop_va = first_va >> 1;
    end else begin
      if (r < 45) len = 48'($urandom_range(1, 40)) << 12;
      else if (r < 75) len = 48'($urandom_range(1, 8)) << 21;
      else if (r < 92) len = 48'($urandom_range(1, 4)) << 30;
      else len = VA_TOP;
      if (r < 92) len = len + 48'($urandom_range(0, 4095));
      sum     = {1'b0, first_va} + {1'b0, len};
      stop_va = sum[AddrW] ? VA_TOP : sum[AddrW-1:0];
    end
    program_regs(root, first_va, stop_va);
  endtask

  function automatic logic [1:0] choose_type(input int unsigned r);
    if (cur_lvl == 0) return (r < 60) ? DESC_TABLE : (r < 97) ? DESC_INVALID : DESC_BLOCK;
    if (cur_lvl == LAST_LEVEL) return (r < 65) ? DESC_PAGE : (r < 97) ? DESC_INVALID : DESC_BLOCK;
    return (r < 50) ? DESC_TABLE : (r < 72) ? DESC_BLOCK : DESC_INVALID;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_empty_range();
    program_regs(48'h0000_1234_5000, '0, '0);
    send_item(ACT_START, '0);
  endtask

  // Scan the last two pages of the address space, all-ones descriptors
  task automatic test_top_of_space();
    program_regs(VA_TOP, VA_TOP - 48'h1FFF, VA_TOP);
    send_item(ACT_START, '1);
    send_item(ACT_DESC, '1);
    send_item(ACT_DESC, '1);
    send_item(ACT_DESC, '1);
    send_item(ACT_DESC, '1);
    send_item(ACT_DESC, '1);
  endtask

  // Block at level 0 ends the scan; a response after that is dropped
  task automatic test_misplaced_block();
    program_regs('0, '0, VA_TOP);
    send_item(ACT_START, '0);
    send_item(ACT_DESC, make_desc(DESC_BLOCK));
    send_item(ACT_DESC, make_desc(DESC_TABLE));
  endtask

  // Restart mid-walk, then a block at the last level
  task automatic test_restart();
    program_regs(48'h0000_00AB_C000, 48'h1234_5678_9000, VA_TOP);
    send_item(ACT_START, rand_word());
    send_item(ACT_DESC, make_desc(DESC_TABLE));
    send_item(ACT_START, rand_word());
    send_item(ACT_DESC, make_desc(DESC_TABLE));
    send_item(ACT_DESC, make_desc(DESC_TABLE));
    send_item(ACT_DESC, make_desc(DESC_TABLE));
    send_item(ACT_DESC, make_desc(DESC_BLOCK));
  endtask

  // Invalid at the last index climbs a level; blocks at levels 2 and 1
  task automatic test_climb_and_blocks();
    program_regs(48'h0000_8000_0000, 48'h0000_001F_F000, 48'h0000_0040_0000);
    send_item(ACT_START, '0);
    send_item(ACT_DESC, make_desc(DESC_TABLE));
    send_item(ACT_DESC, make_desc(DESC_TABLE));
    send_item(ACT_DESC, make_desc(DESC_TABLE));
    send_item(ACT_DESC, '0);
    send_item(ACT_DESC, make_desc(DESC_BLOCK));
    program_regs(48'h0000_0001_0000, 48'h0000_4000_0000, 48'h0000_8000_1000);
    send_item(ACT_START, '0);
    send_item(ACT_DESC, make_desc(DESC_TABLE));
    send_item(ACT_DESC, make_desc(DESC_BLOCK));
    send_item(ACT_DESC, make_desc(DESC_INVALID));
  endtask

  // Receiver holds off while the sender keeps offering; then sender waits for all
  task automatic test_backpressure();
    program_regs(rand48(), '0, VA_TOP);
    idle_on = 1'b0;
    rx_hold_cycles = 400;
    send_item(ACT_START, rand_word());
    repeat (40) send_item(ACT_DESC, make_desc(DESC_INVALID));
    idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_walks(input int unsigned target);
    int unsigned sent;
    int unsigned next_pause;
    int unsigned r;
    sent       = 0;
    next_pause = 250;
    while (sent < target) begin
      // every fifth stretch of a hundred runs with no gaps
      idle_on = ((sent / 100) % 5) != 4;
      if (sent >= next_pause) begin
        wait_drained();
        next_pause += 250;
      end
      if (!scan_on) begin
        if (sent == 0 || $urandom_range(0, 2) != 0) randomize_range();
        if ($urandom_range(0, 5) == 0) send_item(ACT_DESC, rand_word());
        send_item(ACT_START, rand_word());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) send_item(ACT_START, rand_word());
        else send_item(ACT_DESC, make_desc(choose_type($urandom_range(0, 99))));
      end
      sent++;
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_addr_i        = CFG_ROOT;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    action_i          = 1'b0;
    descriptor_word_i = '0;
    reg_root          = '0;
    reg_first         = '0;
    reg_stop          = '0;
    cur_lvl           = '0;
    cursor            = '0;
    scan_on           = 1'b0;
    idle_on           = 1'b1;
    rx_hold_cycles    = 0;
    for (int i = 0; i < Levels; i++) begin
      tbl_idx[i]  = '0;
      tbl_base[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_range();
    test_top_of_space();
    test_misplaced_block();
    test_restart();
    test_climb_and_blocks();
    test_backpressure();
    test_random_walks(RANDOM_ITEMS);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Walked %0d input transfers, checked %0d results:", n_in, n_results);
    $display("  %0d mappings, %0d bad descriptors, %0d scans done", n_maps, n_bad, n_done);
    if (n_errors == 0) begin
      $display("PASS page_table_range_walker");
    end else begin
      $display("FAIL page_table_range_walker");
    end
    $finish;
  end

  // Run limit
  initial begin
    #24_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("FAIL page_table_range_walker");
    $finish;
  end

endmodule

// File: sim.f
design/ptw_pkg.sv
design/ptw_addcmp.sv
design/ptw_outreg.sv
design/page_table_range_walker.sv
test/page_table_range_walker_tb.sv
